// ===== rtl/core/srs_pkg.sv =====
// shared types and constants for the systematic resampler
// no dependencies; imported by every module of the block but srs_ram

package srs_pkg;

  // particle count, a power of two from 2 to 64
  localparam int PARTICLES = 64;
  localparam int IDX_W     = $clog2(PARTICLES);
  localparam int PTR_SHIFT = IDX_W;

  localparam int SLOT_W = 6;
  localparam int W_W    = 17;
  localparam int U_W    = 16;
  localparam int CUM_W  = 23;
  localparam int POS_W  = IDX_W + U_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTICLES - 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [W_W-1:0]   data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

endpackage

// ===== rtl/core/srs_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies

module srs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/srs_weight_store.sv =====
// particle weight store: ram plus per-entry valid bits so reset reads as zero
// depends on srs_pkg and srs_ram

module srs_weight_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  srs_pkg::wr_req_t       wr,
  input  srs_pkg::rd_req_t       rd,
  output logic [srs_pkg::W_W-1:0] rd_data
);
  import srs_pkg::*;

  logic [PARTICLES-1:0] valid_r;
  logic [PARTICLES-1:0] valid_nxt;
  logic                 hit_r;
  logic                 hit_nxt;
  logic [W_W-1:0]       ram_q;

  srs_ram #(
    .WIDTH (W_W),
    .DEPTH (PARTICLES)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (ram_q)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (wr.en) begin
      valid_nxt[wr.addr] = 1'b1;
    end
    hit_nxt = hit_r;
    if (rd.en) begin
      hit_nxt = valid_r[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // never-written entries read as zero
  assign rd_data = hit_r ? ram_q : '0;

endmodule

// ===== rtl/core/srs_walker.sv =====
// pointer walk sequencer: steps the cumulative weight through the store
// and emits one ancestor per draw; depends on srs_pkg

module srs_walker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [srs_pkg::U_W-1:0]   in_random_fraction,
  output srs_pkg::rd_req_t          rd_req,
  input  logic [srs_pkg::W_W-1:0]   rd_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [srs_pkg::IDX_W-1:0] out_ancestor,
  output logic [srs_pkg::IDX_W-1:0] out_draw,
  output logic                      out_last
);
  import srs_pkg::*;

  state_t           state_r, state_nxt;
  logic [U_W-1:0]   u_r, u_nxt;
  logic [IDX_W-1:0] draw_r, draw_nxt;
  logic [IDX_W-1:0] walk_r, walk_nxt;
  logic [IDX_W-1:0] fetch_idx_r, fetch_idx_nxt;
  logic [CUM_W-1:0] cum_r, cum_nxt;

  logic             ov_r, ov_nxt;
  logic [IDX_W-1:0] oanc_r, oanc_nxt;
  logic [IDX_W-1:0] odraw_r, odraw_nxt;
  logic             olast_r, olast_nxt;

  logic             start;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] ptr;
  logic             advance;
  logic             slot_free;
  logic             emit;

  assign start     = in_valid && in_ready && (in_op == OP_START);
  assign pos       = {draw_r, u_r};
  assign ptr       = pos >> PTR_SHIFT;
  assign advance   = (CUM_W'(ptr) > cum_r) && (walk_r != LAST_IDX);
  assign slot_free = !ov_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_WALK: begin
        if (advance) begin
          state_nxt = ST_FETCH;
        end else if (slot_free && (draw_r == LAST_IDX)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FETCH: state_nxt = ST_WALK;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = 1'b0;
    rd_req.en   = 1'b0;
    rd_req.addr = '0;
    emit        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // weight 0 is fetched in the start transaction's cycle
        in_ready  = 1'b1;
        rd_req.en = 1'b1;
      end
      ST_WALK: begin
        if (advance) begin
          rd_req.en   = 1'b1;
          rd_req.addr = walk_r + 1'b1;
        end else begin
          emit = slot_free;
        end
      end
      ST_FETCH: begin
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    u_nxt         = u_r;
    draw_nxt      = draw_r;
    walk_nxt      = walk_r;
    fetch_idx_nxt = fetch_idx_r;
    cum_nxt       = cum_r;
    ov_nxt        = ov_r && !out_ready;
    oanc_nxt      = oanc_r;
    odraw_nxt     = odraw_r;
    olast_nxt     = olast_r;
    if (start) begin
      u_nxt         = in_random_fraction;
      draw_nxt      = '0;
      walk_nxt      = '0;
      fetch_idx_nxt = '0;
      cum_nxt       = '0;
    end
    if (state_r == ST_WALK && advance) begin
      fetch_idx_nxt = walk_r + 1'b1;
    end
    if (state_r == ST_FETCH) begin
      cum_nxt  = cum_r + CUM_W'(rd_data);
      walk_nxt = fetch_idx_r;
    end
    if (emit) begin
      ov_nxt    = 1'b1;
      oanc_nxt  = walk_r;
      odraw_nxt = draw_r;
      olast_nxt = (draw_r == LAST_IDX);
      draw_nxt  = draw_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      walk_r  <= '0;
      cum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      walk_r  <= walk_nxt;
      cum_r   <= cum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r         <= u_nxt;
    draw_r      <= draw_nxt;
    fetch_idx_r <= fetch_idx_nxt;
    oanc_r      <= oanc_nxt;
    odraw_r     <= odraw_nxt;
    olast_r     <= olast_nxt;
  end

  assign out_valid    = ov_r;
  assign out_ancestor = oanc_r;
  assign out_draw     = odraw_r;
  assign out_last     = olast_r;

  a_fetch_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> $past(rd_req.en))
    else $error("fetch state without a read issued");

  a_fetch_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |=> (state_r == ST_WALK))
    else $error("fetch did not return to walk");

  a_walk_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && $past(state_r) != ST_IDLE) |-> (walk_r >= $past(walk_r)))
    else $error("walk index moved backwards within a pass");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && olast_r) |-> (odraw_r == LAST_IDX))
    else $error("last flag on a draw other than the final one");

endmodule

// ===== rtl/core/systematic_resampler_unit.sv =====
// top level of the systematic resampler
// depends on srs_pkg, srs_weight_store and srs_walker

// A write transaction (op 0) stores one Q1.16 weight; a write to a slot at or
// beyond the particle count is dropped. A start transaction (op 1) runs one
// resampling pass and yields one result per particle, in draw order, with last
// set on the final draw. While a pass runs the input is not ready. Each step of
// the weight walk issues a read and then passes through the fetch state, since
// the weight ram has a registered read; the first weight is read in the start
// transaction's cycle. A pass takes longer if the result side stalls. The
// output register lets the walk run one draw ahead of the consumer. Reset
// clears the weights through per-entry valid bits, so no clearing pass is
// needed and the block is ready straight away.

module systematic_resampler_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_op,
  input  logic [srs_pkg::SLOT_W-1:0] in_slot,
  input  logic [srs_pkg::W_W-1:0]    in_weight,
  input  logic [srs_pkg::U_W-1:0]    in_random_fraction,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [srs_pkg::SLOT_W-1:0] out_ancestor_index,
  output logic [srs_pkg::SLOT_W-1:0] out_draw_number,
  output logic                       out_last
);
  import srs_pkg::*;

  wr_req_t          wr_req;
  rd_req_t          rd_req;
  logic [W_W-1:0]   rd_data;
  logic [IDX_W-1:0] anc;
  logic [IDX_W-1:0] draw;

  always_comb begin
    wr_req.en   = in_valid && in_ready && (in_op == OP_WRITE)
                  && ({1'b0, in_slot} < (SLOT_W + 1)'(PARTICLES));
    wr_req.addr = in_slot[IDX_W-1:0];
    wr_req.data = in_weight;
  end

  srs_weight_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr_req),
    .rd      (rd_req),
    .rd_data (rd_data)
  );

  srs_walker u_walker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_random_fraction (in_random_fraction),
    .rd_req             (rd_req),
    .rd_data            (rd_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ancestor       (anc),
    .out_draw           (draw),
    .out_last           (out_last)
  );

  assign out_ancestor_index = SLOT_W'(anc);
  assign out_draw_number    = SLOT_W'(draw);

endmodule

// ===== dv/srs_draw_checker.sv =====
// result checker for the systematic resampler: predicts every draw of a pass
// from the weights it has seen written and compares the result channel in order
// depends on srs_pkg

module srs_draw_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_op,
  input  logic [srs_pkg::SLOT_W-1:0] in_slot,
  input  logic [srs_pkg::W_W-1:0]    in_weight,
  input  logic [srs_pkg::U_W-1:0]    in_random_fraction,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [srs_pkg::SLOT_W-1:0] out_ancestor_index,
  input  logic [srs_pkg::SLOT_W-1:0] out_draw_number,
  input  logic                       out_last,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import srs_pkg::*;

  localparam int STORE_DEPTH = 64;

  typedef struct packed {
    logic [SLOT_W-1:0] ancestor;
    logic [SLOT_W-1:0] draw;
    logic              last;
  } draw_t;

  logic [W_W-1:0]   weights [STORE_DEPTH];
  logic [CUM_W-1:0] running_sum;
  logic [IDX_W-1:0] walk_at;
  draw_t            draws_due [$];

  // one systematic pass: the pointer of draw i is (i + u) / PARTICLES in Q0.16
  function automatic void walk_pass(input logic [U_W-1:0] frac);
    logic [CUM_W-1:0] acc;
    int unsigned      pos;
    int unsigned      j;
    draw_t            d;
    acc = CUM_W'(weights[0]);
    j = 0;
    for (int unsigned i = 0; i < PARTICLES; i++) begin
      pos = ((i << U_W) + frac) / PARTICLES;
      // walk stops on the last particle however small the total weight is
      while (pos > acc && j < PARTICLES - 1) begin
        j++;
        acc = acc + CUM_W'(weights[j % STORE_DEPTH]);
      end
      d.ancestor = SLOT_W'(j);
      d.draw     = SLOT_W'(i);
      d.last     = (i == PARTICLES - 1);
      draws_due.push_back(d);
    end
    running_sum = acc;
    walk_at     = IDX_W'(j);
  endfunction

  always @(posedge clk) begin
    draw_t want;
    if (!rst_n) begin
      foreach (weights[k]) weights[k] = '0;
      running_sum = '0;
      walk_at     = '0;
      draws_due.delete();
      errors = 0;
    end else begin
      // results first, so a draw cannot be matched by a pass started this cycle
      if (out_valid && out_ready) begin
        if (draws_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected draw: ancestor %0d draw %0d last %0b",
                     out_ancestor_index, out_draw_number, out_last);
        end else begin
          want = draws_due.pop_front();
          if (out_ancestor_index !== want.ancestor || out_draw_number !== want.draw ||
              out_last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("draw mismatch: expected ancestor %0d draw %0d last %0b, %s %0d %0d %0b",
                       want.ancestor, want.draw, want.last, "got",
                       out_ancestor_index, out_draw_number, out_last);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_op == OP_START) walk_pass(in_random_fraction);
        else if (in_slot < PARTICLES) weights[in_slot] = in_weight;
      end
    end
    pending = draws_due.size();
  end

endmodule

// ===== dv/testbench.sv =====
// top of the systematic resampler testbench: clock, reset, stimulus, verdict
// depends on srs_pkg, systematic_resampler_unit and srs_draw_checker

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import srs_pkg::*;

  localparam int RANDOM_ITEMS = 360;
  localparam int QUIET_ITEMS  = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [W_W-1:0] ONE   = W_W'(65536);
  localparam logic [W_W-1:0] W_MAX = '1;

  logic              clk                = 1'b0;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_ready;
  logic              in_op              = OP_WRITE;
  logic [SLOT_W-1:0] in_slot            = '0;
  logic [W_W-1:0]    in_weight          = '0;
  logic [U_W-1:0]    in_random_fraction = '0;
  logic              out_valid;
  logic              out_ready          = 1'b1;
  logic [SLOT_W-1:0] out_ancestor_index;
  logic [SLOT_W-1:0] out_draw_number;
  logic              out_last;

  int errors;
  int pending;
  int items_sent = 0;
  int cycles     = 0;
  int stall_left = 0;
  bit quiet      = 1'b0;

  always #1 clk = ~clk;

  systematic_resampler_unit DUT (.*);

  srs_draw_checker draw_check (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // result side back-pressure in short bursts
  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                           input logic [W_W-1:0] w, input logic [U_W-1:0] frac);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid           <= 1'b0;
      in_op              <= 1'($urandom);
      in_slot            <= SLOT_W'($urandom);
      in_weight          <= W_W'($urandom);
      in_random_fraction <= U_W'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_op              <= op;
    in_slot            <= slot;
    in_weight          <= w;
    in_random_fraction <= frac;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_weight(input logic [SLOT_W-1:0] slot, input logic [W_W-1:0] w);
    send_item(OP_WRITE, slot, w, U_W'($urandom));
  endtask

  task automatic start_pass(input logic [U_W-1:0] frac);
    send_item(OP_START, SLOT_W'($urandom), W_W'($urandom), frac);
  endtask

  function automatic logic [U_W-1:0] pick_fraction();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return U_W'($urandom);
    endcase
  endfunction

  // writes a full weight set in shuffled slot order
  task automatic load_distribution();
    logic [W_W-1:0] plan [PARTICLES];
    int unsigned    order [PARTICLES];
    int unsigned    left;
    int unsigned    mode;
    int unsigned    j;
    int unsigned    tmp;
    int unsigned    x;
    int unsigned    y;
    left = 65536;
    mode = $urandom_range(0, 3);
    for (int k = 0; k < PARTICLES; k++) begin
      order[k] = k;
      case (mode)
        0: plan[k] = W_W'(65536 / PARTICLES);
        1: begin
          if (k == PARTICLES - 1) plan[k] = W_W'(left);
          else plan[k] = W_W'($urandom_range(0, 2 * left / (PARTICLES - k)));
          left -= plan[k];
        end
        // total under or over one
        3: plan[k] = W_W'($urandom_range(0, $urandom_range(256, 4095)));
        default: plan[k] = '0;
      endcase
    end
    if (mode == 2) begin
      // a few heavy particles sharing the whole weight
      x = $urandom_range(0, 65536);
      y = $urandom_range(0, 65536 - x);
      j = $urandom_range(0, PARTICLES - 1);
      plan[j] += W_W'(x);
      j = $urandom_range(0, PARTICLES - 1);
      plan[j] += W_W'(y);
      j = $urandom_range(0, PARTICLES - 1);
      plan[j] += W_W'(65536 - x - y);
    end
    for (int k = PARTICLES - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) write_weight(SLOT_W'(order[k]), plan[order[k]]);
  endtask

  initial begin
    int kind;
    int total;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // store still clear: the walk runs to the last particle once the pointer is above zero
    start_pass('0);
    start_pass('1);
    write_weight('0, ONE);
    start_pass('0);
    start_pass('1);
    write_weight('0, '0);
    write_weight(SLOT_W'(PARTICLES - 1), W_MAX);
    write_weight(SLOT_W'(PARTICLES / 2), W_W'(65535));
    start_pass(U_W'(32768));
    // weight above one in the first slot
    write_weight('0, W_MAX);
    write_weight(SLOT_W'(1), W_W'(1));
    send_item(OP_START, '1, W_MAX, '1);
    send_item(OP_WRITE, SLOT_W'(2), W_W'(4096), '1);
    send_item(OP_START, '0, '0, U_W'(1));
    write_weight('0, W_W'(21845));
    write_weight(SLOT_W'(PARTICLES - 1), '0);
    send_item(OP_START, SLOT_W'(21), W_W'(43690), U_W'(43690));
    send_item(OP_WRITE, SLOT_W'(42), W_W'(21845), U_W'(21845));
    start_pass(U_W'(1023));

    total = items_sent + RANDOM_ITEMS;
    while (items_sent < total) begin
      quiet = (total - items_sent) < QUIET_ITEMS;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        load_distribution();
        start_pass(pick_fraction());
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 6))
          write_weight(SLOT_W'($urandom), W_W'($urandom_range(0, 65536)));
        start_pass(pick_fraction());
      end else begin
        repeat ($urandom_range(1, 3)) write_weight(SLOT_W'($urandom), W_W'($urandom));
        if ($urandom_range(0, 1) == 1) start_pass(pick_fraction());
      end
    end

    in_valid <= 1'b0;
    quiet = 1'b1;
    while (pending != 0) @(negedge clk);
    repeat (3 * PARTICLES) @(negedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
